>>> sv/assert_macros.svh
// ------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of this project.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_NR(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

>>> sv/lci_pkg.sv
`default_nettype none
// ------------------------------------------------------------------------
// lci_pkg
// Constants, types and matcher functions of the line command interpreter.
// ------------------------------------------------------------------------
package lci_pkg;

    localparam int LINE_LIMIT      = 256;
    localparam int CMD_WORD_BUFFER = 32;
    localparam int LINE_CNT_W      = $clog2(LINE_LIMIT);
    localparam int WORD_LEN_W      = $clog2(CMD_WORD_BUFFER);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [39:0] KEY_CMD = {CH_QUOTE, "cmd", CH_QUOTE};
    localparam logic [39:0] KEY_PIN = {CH_QUOTE, "pin", CH_QUOTE};
    localparam logic [39:0] KEY_VAL = {CH_QUOTE, "val", CH_QUOTE};

    localparam logic [47:0] WORD_SET    = {"set", 24'h000000};
    localparam logic [47:0] WORD_GET    = {"get", 24'h000000};
    localparam logic [47:0] WORD_TOGGLE = "toggle";

    // matcher stages; 0..4 count matched key characters
    localparam logic [3:0] KS_START = 4'd0;
    localparam logic [3:0] KS_SKIP  = 4'd5;
    localparam logic [3:0] KS_BODY  = 4'd6;
    localparam logic [3:0] KS_DONE  = 4'd7;
    localparam logic [3:0] KS_FAIL  = 4'd8;

    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_MISSING_CMD = 3'd1;
    localparam logic [2:0] STAT_MISSING_PIN = 3'd2;
    localparam logic [2:0] STAT_MISSING_VAL = 3'd3;
    localparam logic [2:0] STAT_BAD_PIN     = 3'd4;
    localparam logic [2:0] STAT_UNKNOWN_CMD = 3'd5;

    localparam logic [1:0] CMD_SET    = 2'd0;
    localparam logic [1:0] CMD_GET    = 2'd1;
    localparam logic [1:0] CMD_TOGGLE = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [31:0] MAG_CAP = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [3:0]            stage;
        logic [2:0]            match;   // bit 0 set, bit 1 get, bit 2 toggle
        logic [WORD_LEN_W-1:0] len;
    } cmd_match_t;

    typedef struct packed {
        logic [3:0]  stage;
        logic [31:0] acc;
        logic        neg;
    } num_match_t;

    function automatic logic [3:0] key_advance(logic [3:0] k, logic [39:0] pat,
                                               logic [7:0] b);
        logic [7:0] c;
        logic [3:0] r;
        case (k)
            4'd0:    c = pat[39:32];
            4'd1:    c = pat[31:24];
            4'd2:    c = pat[23:16];
            4'd3:    c = pat[15:8];
            4'd4:    c = pat[7:0];
            default: c = CH_NUL;
        endcase
        if (k < KS_SKIP && b == c) begin
            r = k + 4'd1;
        end else if (b == CH_QUOTE) begin
            r = 4'd1;
        end else begin
            r = KS_START;
        end
        return r;
    endfunction

    function automatic logic [7:0] word_char(logic [47:0] pat, logic [2:0] n);
        logic [7:0] c;
        case (n)
            3'd0:    c = pat[47:40];
            3'd1:    c = pat[39:32];
            3'd2:    c = pat[31:24];
            3'd3:    c = pat[23:16];
            3'd4:    c = pat[15:8];
            3'd5:    c = pat[7:0];
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic cmd_match_t cmd_feed(cmd_match_t cur, logic [7:0] b);
        cmd_match_t nxt;
        logic [2:0] n;
        logic       short_word;
        logic       mid_word;
        nxt        = cur;
        n          = cur.len[2:0];
        short_word = cur.len < WORD_LEN_W'(3);
        mid_word   = cur.len < WORD_LEN_W'(6);
        if (cur.stage < KS_SKIP) begin
            nxt.stage = key_advance(cur.stage, KEY_CMD, b);
        end else if (cur.stage == KS_SKIP) begin
            if (b == CH_QUOTE) begin
                nxt.stage = KS_BODY;
                nxt.len   = '0;
                nxt.match = 3'b111;
            end else if (!(b == CH_SPACE || b == CH_COLON)) begin
                nxt.stage = KS_FAIL;
            end
        end else if (cur.stage == KS_BODY) begin
            if (b == CH_QUOTE || cur.len >= WORD_LEN_W'(CMD_WORD_BUFFER - 1)) begin
                nxt.stage = KS_DONE;
            end else begin
                nxt.match[0] = cur.match[0] && short_word && b == word_char(WORD_SET, n);
                nxt.match[1] = cur.match[1] && short_word && b == word_char(WORD_GET, n);
                nxt.match[2] = cur.match[2] && mid_word && b == word_char(WORD_TOGGLE, n);
                nxt.len      = cur.len + WORD_LEN_W'(1);
            end
        end
        return nxt;
    endfunction

    function automatic num_match_t num_feed(num_match_t cur, logic [39:0] pat,
                                            logic [7:0] b);
        num_match_t  nxt;
        logic        digit;
        logic [35:0] v;
        nxt   = cur;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        // acc * 10 + digit as two shifts and an add
        v     = 36'({cur.acc, 3'b000}) + 36'({cur.acc, 1'b0}) + 36'(b[3:0]);
        if (cur.stage < KS_SKIP) begin
            nxt.stage = key_advance(cur.stage, pat, b);
        end else if (cur.stage == KS_SKIP) begin
            if (b == CH_MINUS) begin
                nxt.neg   = 1'b1;
                nxt.acc   = '0;
                nxt.stage = KS_BODY;
            end else if (digit) begin
                nxt.neg   = 1'b0;
                nxt.acc   = 32'(b[3:0]);
                nxt.stage = KS_BODY;
            end else if (!(b == CH_SPACE || b == CH_COLON)) begin
                nxt.stage = KS_FAIL;
            end
        end else if (cur.stage == KS_BODY) begin
            if (digit) begin
                nxt.acc = (v > 36'(MAG_CAP)) ? MAG_CAP : v[31:0];
            end else begin
                nxt.stage = KS_DONE;
            end
        end
        return nxt;
    endfunction

    function automatic logic signed [31:0] num_value(logic [31:0] acc, logic neg);
        logic [31:0] r;
        if (neg) begin
            r = -acc;
        end else if (acc > POS_MAX) begin
            r = POS_MAX;
        end else begin
            r = acc;
        end
        return signed'(r);
    endfunction

endpackage
`default_nettype wire

>>> sv/line_command_interpreter.sv
`default_nettype none
// ------------------------------------------------------------------------
// line_command_interpreter
// Byte-serial command line parser with LED state and pin check.
// ------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready/s_rx_data carries one received byte per
//   word. Three key matchers (cmd, pin, val) update their state as each
//   byte is accepted, so one byte is taken every cycle while s_ready is high.
//   A CR or LF that ends a non-empty line loads one result word into the
//   output register; m_valid rises in the cycle after that byte is accepted.
//   Empty lines, and all other bytes, give no result.
//   While a result waits on m_ready, ordinary bytes are still accepted;
//   only a line-end byte is held back (s_ready low) until the output
//   register is free or is being taken in the same cycle.
//   cfg_wr_en/cfg_wr_data write supported_pin, no read-back.
//   Synchronous active-low aresetn clears the line buffer state, the lamp
//   state (off, not m_led_on) and the output valid, and sets supported_pin to 13.
// ------------------------------------------------------------------------
module line_command_interpreter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [1:0]         m_command,
    output logic signed [31:0] m_pin_number,
    output logic signed [31:0] m_reported_value,
    output logic               m_led_on
);
    import lci_pkg::*;

    logic [7:0]            supported_pin_reg, supported_pin_next;
    logic [LINE_CNT_W-1:0] line_count_reg, line_count_next;
    logic                  nul_seen_reg, nul_seen_next;
    logic                  lamp_state_reg, lamp_state_next;
    cmd_match_t            cmd_reg, cmd_next;
    num_match_t            pin_reg, pin_next;
    num_match_t            val_reg, val_next;
    logic                  m_valid_reg, m_valid_next;
    logic [2:0]            status_reg, status_next;
    logic [1:0]            command_reg, command_next;
    logic signed [31:0]    pin_number_reg, pin_number_next;
    logic signed [31:0]    reported_reg, reported_next;
    logic                  led_reg, led_next;

    logic               is_eol;
    logic               accept;
    logic               byte_hidden;
    logic               cmd_ok, pin_ok, val_ok;
    logic [1:0]         res_command;
    logic [2:0]         res_status;
    logic signed [31:0] pin_val, val_val;
    logic signed [31:0] res_pin, res_rep;
    logic               res_lamp;

    assign is_eol  = (s_rx_data == CH_CR) || (s_rx_data == CH_LF);
    assign s_ready = !m_valid_reg || m_ready || !is_eol;
    assign accept  = s_valid && s_ready;

    // line-end decision from the state left by the bytes so far
    always_comb begin
        cmd_ok      = (cmd_reg.stage == KS_BODY) || (cmd_reg.stage == KS_DONE);
        pin_ok      = (pin_reg.stage == KS_BODY) || (pin_reg.stage == KS_DONE);
        val_ok      = (val_reg.stage == KS_BODY) || (val_reg.stage == KS_DONE);
        pin_val     = num_value(pin_reg.acc, pin_reg.neg);
        val_val     = num_value(val_reg.acc, val_reg.neg);
        res_command = CMD_NONE;
        res_status  = STAT_MISSING_CMD;
        res_pin     = '0;
        res_rep     = '0;
        res_lamp    = lamp_state_reg;
        if (cmd_ok) begin
            if (cmd_reg.match[0] && cmd_reg.len == WORD_LEN_W'(3)) begin
                res_command = CMD_SET;
            end else if (cmd_reg.match[1] && cmd_reg.len == WORD_LEN_W'(3)) begin
                res_command = CMD_GET;
            end else if (cmd_reg.match[2] && cmd_reg.len == WORD_LEN_W'(6)) begin
                res_command = CMD_TOGGLE;
            end
            if (res_command == CMD_NONE) begin
                res_status = STAT_UNKNOWN_CMD;
            end else if (!pin_ok) begin
                res_status = STAT_MISSING_PIN;
            end else begin
                res_pin = pin_val;
                if (res_command == CMD_SET && !val_ok) begin
                    res_status = STAT_MISSING_VAL;
                end else if (pin_val != signed'({24'b0, supported_pin_reg})) begin
                    res_status = STAT_BAD_PIN;
                end else begin
                    res_status = STAT_OK;
                    if (res_command == CMD_SET) begin
                        res_rep  = val_val;
                        res_lamp = (val_val != '0);
                    end else begin
                        res_lamp = (res_command == CMD_TOGGLE) ? !lamp_state_reg
                                                               : lamp_state_reg;
                        res_rep  = signed'({31'b0, res_lamp});
                    end
                end
            end
        end
    end

    always_comb begin
        supported_pin_next = cfg_wr_en ? cfg_wr_data : supported_pin_reg;
        line_count_next    = line_count_reg;
        nul_seen_next      = nul_seen_reg;
        lamp_state_next    = lamp_state_reg;
        cmd_next           = cmd_reg;
        pin_next           = pin_reg;
        val_next           = val_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        status_next        = status_reg;
        command_next       = command_reg;
        pin_number_next    = pin_number_reg;
        reported_next      = reported_reg;
        led_next           = led_reg;
        byte_hidden        = nul_seen_reg || (s_rx_data == CH_NUL);

        if (accept && !is_eol) begin
            // drop bytes once the line buffer is full
            if (line_count_reg < LINE_CNT_W'(LINE_LIMIT - 1)) begin
                line_count_next = line_count_reg + LINE_CNT_W'(1);
                nul_seen_next   = byte_hidden;
                if (!byte_hidden) begin
                    cmd_next = cmd_feed(cmd_reg, s_rx_data);
                    pin_next = num_feed(pin_reg, KEY_PIN, s_rx_data);
                    val_next = num_feed(val_reg, KEY_VAL, s_rx_data);
                end
            end
        end else if (accept && line_count_reg != '0) begin
            m_valid_next    = 1'b1;
            status_next     = res_status;
            command_next    = res_command;
            pin_number_next = res_pin;
            reported_next   = res_rep;
            led_next        = res_lamp;
            lamp_state_next = res_lamp;
            line_count_next = '0;
            nul_seen_next   = 1'b0;
            cmd_next        = '0;
            pin_next        = '0;
            val_next        = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            supported_pin_reg <= 8'd13;
            line_count_reg    <= '0;
            nul_seen_reg      <= 1'b0;
            lamp_state_reg    <= 1'b0;
            cmd_reg           <= '0;
            pin_reg           <= '0;
            val_reg           <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            supported_pin_reg <= supported_pin_next;
            line_count_reg    <= line_count_next;
            nul_seen_reg      <= nul_seen_next;
            lamp_state_reg    <= lamp_state_next;
            cmd_reg           <= cmd_next;
            pin_reg           <= pin_next;
            val_reg           <= val_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg     <= status_next;
        command_reg    <= command_next;
        pin_number_reg <= pin_number_next;
        reported_reg   <= reported_next;
        led_reg        <= led_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_command        = command_reg;
    assign m_pin_number     = pin_number_reg;
    assign m_reported_value = reported_reg;
    assign m_led_on         = led_reg;

endmodule
`default_nettype wire

>>> sv/lci_checker.sv
`default_nettype none
// ------------------------------------------------------------------------
// lci_checker
// Port-level assertions for the line command interpreter, bound to it.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module lci_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               cfg_wr_en,
    input wire logic [7:0]         cfg_wr_data,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic [7:0]         s_rx_data,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [2:0]         m_status,
    input wire logic [1:0]         m_command,
    input wire logic signed [31:0] m_pin_number,
    input wire logic signed [31:0] m_reported_value,
    input wire logic               m_led_on
);
    import lci_pkg::*;

    // a stalled result word holds
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_reported_value) && $stable(m_led_on))

    `ASSERT_CLK_NR(a_reset_clears, aclk, !aresetn |=> !m_valid)

    `ASSERT_CLK(a_no_cmd_none, aclk, aresetn, m_valid && m_status == STAT_MISSING_CMD |-> m_command == CMD_NONE && m_pin_number == 0)

    `ASSERT_CLK(a_fail_no_value, aclk, aresetn, m_valid && m_status != STAT_OK |-> m_reported_value == 0)

    // get and toggle echo the LED state
    `ASSERT_CLK(a_get_echo, aclk, aresetn, m_valid && m_status == STAT_OK && m_command != CMD_SET |-> m_reported_value[0] == m_led_on && m_reported_value[31:1] == '0)

endmodule

bind line_command_interpreter lci_checker u_lci_checker (.*);
`default_nettype wire
